// ----- rtl/core/first_fit_heap_allocator_macros.svh -----
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, disabled while reset is low.
`define FFHA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, also during reset.
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFHA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/ffha_pkg.sv -----
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;
    localparam int HEAP_BYTES_DEF   = 67108864;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int MIN_SPLIT_DATA   = 4;
    localparam logic [31:0] HEAP_BASE_RESET = 32'h0100_0000;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_ZERO = 3'd1,
        ST_OOM  = 3'd2,
        ST_FULL = 3'd3,
        ST_NULL = 3'd4,
        ST_BAD  = 3'd5
    } t_status;

    typedef struct packed {
        logic        func;
        logic [25:0] request_size;
        logic [31:0] release_address;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] data_address;
        logic [25:0] used_total;
        logic [25:0] live_bytes;
        logic [25:0] spare_bytes;
        logic [6:0]  live_count;
        logic [6:0]  spare_count;
    } t_rsp;
endpackage

// ----- rtl/core/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: scan sequencer and statistics.
//
//  channel   direction  handshake                    payload
//  request   in         i_in_valid / o_in_ready      i_in  (t_req)
//  result    out        o_out_valid / i_out_ready    o_out (t_rsp)
//  config    in         i_cfg_we (no wait)           i_cfg_wdata (heap_base)
//
// One transaction at a time. Zero-size and null requests skip the table.
// Others scan the table one entry per cycle through its registered read
// port; a split adds two table writes, after the entries behind the hit
// have each moved one slot up. The scan stops at the hit or at the last
// entry. The table, with one read and one write port, sets the pace.
// Synchronous active-low reset clears counters and stats; the table needs
// no clearing since only entries below the count are read.
// A finished result waits in the output register; a new request may be
// taken meanwhile and its result waits until that register frees up.
`include "first_fit_heap_allocator_macros.svh"
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    // Size arithmetic wide enough for heap offsets and request + header sums.
    localparam int HB_W = $clog2(HEAP_BYTES + 1);
    localparam int SW   = (HB_W > 27 ? HB_W : 27) + 1;
    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int CW   = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_WR_NEW, S_WR_HIT, S_MISS, S_EMIT
    } t_state;

    t_state          r_state;
    logic [31:0]     r_base;
    logic            r_func;
    logic [25:0]     r_n;
    logic [31:0]     r_a;
    logic [SW-1:0]   r_total;
    logic [CW-1:0]   r_count;
    logic [SW-1:0]   r_used;
    logic [SW-1:0]   r_abytes;
    logic [SW-1:0]   r_fbytes;
    logic [CW-1:0]   r_acnt;
    logic [CW-1:0]   r_fcnt;
    logic [CW-1:0]   r_idx;      // entry whose data is on the read port
    logic [SW-1:0]   r_off;      // byte offset of that entry
    logic [CW-1:0]   r_hit_idx;
    logic [SW-1:0]   r_hit_size;
    logic [CW-1:0]   r_sh;       // next entry to read during the shift
    logic [CW-1:0]   r_shp;      // entry whose data is on the read port
    logic            r_sh_v;
    logic            r_more;
    t_status         r_st;
    logic [31:0]     r_addr;
    logic            r_out_v;
    t_rsp            r_out;

    // table word: {size, free mark}
    logic [SW:0]     mem_q;
    logic [SW-1:0]   q_size;
    logic            q_free;
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    logic [SW:0]     mem_wd;
    logic [IW-1:0]   mem_ra;

    logic [CW-1:0]   idx_nx;
    logic [CW-1:0]   hit_nx;
    logic [CW-1:0]   shp_nx;
    logic [31:0]     addr_calc;
    logic [SW-1:0]   q_data;
    logic            hit;
    logic            can_split;
    logic            last;
    logic            no_room;

    ffha_table #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (SW + 1)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (mem_ra),
        .o_rdata (mem_q)
    );

    assign q_size    = mem_q[SW:1];
    assign q_free    = mem_q[0];
    assign q_data    = q_size - SW'(HEADER_BYTES);
    assign idx_nx    = r_idx + CW'(1);
    assign hit_nx    = r_hit_idx + CW'(1);
    assign shp_nx    = r_shp + CW'(1);
    assign last      = (idx_nx == r_count);
    assign addr_calc = r_base + 32'(r_off) + 32'(HEADER_BYTES);
    assign hit       = (r_func == FUNC_FREE) ? (!q_free && addr_calc == r_a)
                                             : (q_free && q_size >= r_total);
    assign can_split = (q_size >= r_total + SW'(HEADER_BYTES + MIN_SPLIT_DATA))
                       && (r_count < CW'(MAX_BLOCKS));
    assign no_room   = (r_used + r_total >= SW'(HEAP_BYTES));

    // Table port steering.
    always_comb begin
        mem_ra = '0;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        unique case (r_state)
            S_SCAN: begin
                mem_ra = idx_nx[IW-1:0];
                // whole-block alloc or free rewrites the entry in place
                mem_we = hit && !(r_func == FUNC_ALLOC && can_split);
                mem_wa = r_idx[IW-1:0];
                mem_wd = {q_size, r_func == FUNC_FREE};
            end
            S_SHIFT: begin
                mem_ra = r_sh[IW-1:0];
                mem_we = r_sh_v;
                mem_wa = shp_nx[IW-1:0];
                mem_wd = mem_q;
            end
            S_WR_NEW: begin
                mem_we = 1'b1;
                mem_wa = hit_nx[IW-1:0];
                mem_wd = {r_hit_size - r_total, 1'b1};
            end
            S_WR_HIT: begin
                mem_we = 1'b1;
                mem_wa = r_hit_idx[IW-1:0];
                mem_wd = {r_total, 1'b0};
            end
            S_MISS: begin
                mem_we = (r_func == FUNC_ALLOC) && !no_room
                         && (r_count < CW'(MAX_BLOCKS));
                mem_wa = r_count[IW-1:0];
                mem_wd = {r_total, 1'b0};
            end
            default: begin
                mem_ra = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= HEAP_BASE_RESET;
            r_count  <= '0;
            r_used   <= '0;
            r_abytes <= '0;
            r_fbytes <= '0;
            r_acnt   <= '0;
            r_fcnt   <= '0;
            r_out_v  <= 1'b0;
            r_sh_v   <= 1'b0;
            r_more   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            // in S_EMIT the output register is handled below
            if (r_out_v && i_out_ready && r_state != S_EMIT) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_in.func;
                        r_n     <= i_in.request_size;
                        r_a     <= i_in.release_address;
                        r_total <= SW'(i_in.request_size) + SW'(HEADER_BYTES);
                        r_addr  <= '0;
                        r_idx   <= '0;
                        r_off   <= '0;
                        if (i_in.func == FUNC_ALLOC && i_in.request_size == '0) begin
                            r_st    <= ST_ZERO;
                            r_state <= S_EMIT;
                        end else if (i_in.func == FUNC_FREE
                                     && i_in.release_address == '0) begin
                            r_st    <= ST_NULL;
                            r_state <= S_EMIT;
                        end else if (r_count == '0) begin
                            r_st    <= ST_OK;
                            r_state <= S_MISS;
                        end else begin
                            r_st    <= ST_OK;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        if (r_func == FUNC_FREE) begin
                            r_acnt   <= r_acnt - CW'(1);
                            r_fcnt   <= r_fcnt + CW'(1);
                            r_abytes <= r_abytes - q_data;
                            r_fbytes <= r_fbytes + q_data;
                            r_state  <= S_EMIT;
                        end else begin
                            r_addr <= addr_calc;
                            r_acnt <= r_acnt + CW'(1);
                            if (can_split) begin
                                // free count unchanged: the remainder stays free
                                r_hit_idx  <= r_idx;
                                r_hit_size <= q_size;
                                r_abytes   <= r_abytes + SW'(r_n);
                                r_fbytes   <= r_fbytes - r_total;
                                if (idx_nx < r_count) begin
                                    r_sh    <= r_count - CW'(1);
                                    r_more  <= 1'b1;
                                    r_sh_v  <= 1'b0;
                                    r_state <= S_SHIFT;
                                end else begin
                                    r_state <= S_WR_NEW;
                                end
                            end else begin
                                r_fcnt   <= r_fcnt - CW'(1);
                                r_abytes <= r_abytes + q_data;
                                r_fbytes <= r_fbytes - q_data;
                                r_state  <= S_EMIT;
                            end
                        end
                    end else if (last) begin
                        r_state <= S_MISS;
                    end else begin
                        r_idx <= idx_nx;
                        r_off <= r_off + q_size;
                    end
                end
                S_SHIFT: begin
                    // read entry r_sh while the previous one lands one slot up
                    if (r_more) begin
                        r_shp  <= r_sh;
                        r_sh_v <= 1'b1;
                        if (r_sh == hit_nx) begin
                            r_more <= 1'b0;
                        end else begin
                            r_sh <= r_sh - CW'(1);
                        end
                    end else begin
                        r_sh_v  <= 1'b0;
                        r_state <= S_WR_NEW;
                    end
                end
                S_WR_NEW: begin
                    r_state <= S_WR_HIT;
                end
                S_WR_HIT: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_EMIT;
                end
                S_MISS: begin
                    if (r_func == FUNC_FREE) begin
                        r_st <= ST_BAD;
                    end else if (no_room) begin
                        r_st <= ST_OOM;
                    end else if (r_count >= CW'(MAX_BLOCKS)) begin
                        r_st <= ST_FULL;
                    end else begin
                        r_addr   <= r_base + 32'(r_used) + 32'(HEADER_BYTES);
                        r_used   <= r_used + r_total;
                        r_count  <= r_count + CW'(1);
                        r_acnt   <= r_acnt + CW'(1);
                        r_abytes <= r_abytes + SW'(r_n);
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_v || i_out_ready) begin
                        r_out_v             <= 1'b1;
                        r_out.status        <= r_st;
                        r_out.data_address  <= r_addr;
                        r_out.used_total    <= 26'(r_used);
                        r_out.live_bytes    <= 26'(r_abytes);
                        r_out.spare_bytes   <= 26'(r_fbytes);
                        r_out.live_count    <= 7'(r_acnt);
                        r_out.spare_count   <= 7'(r_fcnt);
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    `FFHA_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(MAX_BLOCKS), "table count overflow")
    `FFHA_ASSERT(a_block_sum, i_clk, i_rst_n, (r_state == S_IDLE) |-> (r_acnt + r_fcnt == r_count), "block counts disagree with table")
    `FFHA_ASSERT(a_used_max, i_clk, i_rst_n, r_used < SW'(HEAP_BYTES), "used bytes reached heap size")
    `FFHA_ASSERT(a_shift_port, i_clk, i_rst_n, (r_state == S_SHIFT && mem_we) |-> (mem_wa != mem_ra), "shift write hits entry being read")
endmodule

// ----- rtl/core/ffha_table.sv -----
// Block table memory: one write port, one registered read port.
module ffha_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
